FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and wrapping 64-bit multiply helpers for the compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAL_TEMP    = 2'd0,
    CFG_CAL_PRESS_1 = 2'd1,
    CFG_CAL_PRESS_2 = 2'd2,
    CFG_CAL_PRESS_3 = 2'd3
  } cfg_idx_e;

  localparam int unsigned QUOT_W = 64;          // dividend and quotient width
  localparam int unsigned DEN_W  = 31;          // divisor is a 31-bit signed value
  localparam int unsigned REM_W  = DEN_W + 1;   // partial remainder width
  localparam int unsigned TC_W   = 32;

  localparam logic [32:0] FINE_OFFSET = 33'd128000;
  localparam logic [20:0] P_BASE      = 21'd1048576;
  localparam logic [63:0] DIV_SCALE   = 64'd3125;
  localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

  // Partial products of a 64 x 64 multiply reduced modulo 2^64.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] x;
  } pp_t;

  // Side data carried through the divider.
  typedef struct packed {
    logic [TC_W-1:0] tc;
    logic            neg;
    logic            zero;
  } div_side_t;

  function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
    pp_t         r;
    logic [63:0] x1;
    logic [63:0] x2;
    r.ll = a[31:0] * b[31:0];
    x1   = a[31:0] * b[63:32];
    x2   = a[63:32] * b[31:0];
    r.x  = x1[31:0] + x2[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(pp_t p);
    return p.ll + {p.x, 32'b0};
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bsc_div.sv
// Pipelined signed 64 by 31-bit truncating divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module bsc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        in_valid_i,
  input  wire logic [bsc_pkg::QUOT_W-1:0]  num_i,
  input  wire logic [bsc_pkg::DEN_W-1:0]   den_i,
  input  wire logic [bsc_pkg::TC_W-1:0]    tc_i,
  output logic                             out_valid_o,
  output logic [bsc_pkg::QUOT_W-1:0]       quot_o,
  output logic                             zero_o,
  output logic [bsc_pkg::TC_W-1:0]         tc_o
);
  import bsc_pkg::*;

  localparam int unsigned NSTEP = QUOT_W;

  logic [NSTEP+1:0]    vld_q;
  logic [REM_W-1:0]    rem_q  [NSTEP+1];
  logic [QUOT_W-1:0]   nq_q   [NSTEP+1];
  logic [DEN_W-1:0]    d_q    [NSTEP+1];
  div_side_t           side_q [NSTEP+1];
  logic [REM_W-1:0]    r2     [NSTEP];
  logic [NSTEP-1:0]    ge;
  logic [QUOT_W-1:0]   quot_q;
  logic                zero_q;
  logic [TC_W-1:0]     tc_q;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTEP:0], in_valid_i};
    end
  end

  // Operands become magnitudes; the signs and the zero check ride along.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]       <= '0;
      nq_q[0]        <= num_i[QUOT_W-1] ? (~num_i + 1'b1) : num_i;
      d_q[0]         <= den_i[DEN_W-1] ? (~den_i + 1'b1) : den_i;
      side_q[0].tc   <= tc_i;
      side_q[0].neg  <= num_i[QUOT_W-1] ^ den_i[DEN_W-1];
      side_q[0].zero <= (den_i == '0);
    end
  end

  // Restoring division steps.
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    assign r2[k] = {rem_q[k][REM_W-2:0], nq_q[k][QUOT_W-1]};
    assign ge[k] = (r2[k] >= {1'b0, d_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge[k] ? (r2[k] - {1'b0, d_q[k]}) : r2[k];
        nq_q[k+1]   <= {nq_q[k][QUOT_W-2:0], ge[k]};
        d_q[k+1]    <= d_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // Apply the quotient sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= side_q[NSTEP].neg ? (~nq_q[NSTEP] + 1'b1) : nq_q[NSTEP];
      zero_q <= side_q[NSTEP].zero;
      tc_q   <= side_q[NSTEP].tc;
    end
  end

  assign out_valid_o = vld_q[NSTEP+1];
  assign quot_o      = quot_q;
  assign zero_o      = zero_q;
  assign tc_o        = tc_q;

endmodule
`default_nettype wire

FILE: rtl/core/barometric_sensor_compensation.sv
// Top level of the pipelined barometric temperature and pressure compensation.
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw temperature and pressure pair per beat and returns the temperature in
// hundredths of a degree and the pressure in pascal as unsigned Q24.8 (low 32 bits).
// The pipeline accepts one beat every cycle unless the output register holds an untaken beat;
// the pressure quotient is formed by the 64-stage divider.
// When the pressure divisor comes out zero, pressure is 0 and pressure_valid_o is low.
// Calibration registers are written through the configuration channel, which is always
// ready; write them only while no beat is in flight.
module barometric_sensor_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] raw_temperature_i,
  input  wire logic [19:0] raw_pressure_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      temperature_centi_o,
  output logic [31:0]      pressure_q24_8_o,
  output logic             pressure_valid_o
);
  import bsc_pkg::*;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_1_q;
  logic [63:0] cal_press_2_q;
  logic [15:0] cal_press_3_q;
  logic        en;

  // Calibration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_1_q <= '0;
      cal_press_2_q <= '0;
      cal_press_3_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CAL_TEMP:    cal_temp_q    <= cfg_data_i[47:0];
        CFG_CAL_PRESS_1: cal_press_1_q <= cfg_data_i;
        CFG_CAL_PRESS_2: cal_press_2_q <= cfg_data_i;
        CFG_CAL_PRESS_3: cal_press_3_q <= cfg_data_i[15:0];
        default:         cal_temp_q    <= cal_temp_q;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_press_1_q[15:0];
  assign p2 = cal_press_1_q[31:16];
  assign p3 = cal_press_1_q[47:32];
  assign p4 = cal_press_1_q[63:48];
  assign p5 = cal_press_2_q[15:0];
  assign p6 = cal_press_2_q[31:16];
  assign p7 = cal_press_2_q[47:32];
  assign p8 = cal_press_2_q[63:48];
  assign p9 = cal_press_3_q;

  // The whole pipeline advances unless the output register holds an untaken beat.
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [10:0] fv_q;
  logic [4:0]  bv_q;
  logic        div_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      fv_q        <= {fv_q[9:0], in_valid_i};
      bv_q        <= {bv_q[3:0], div_valid};
      out_valid_q <= bv_q[4];
    end
  end

  // Temperature front end.
  logic [17:0]        d1;
  logic [16:0]        d2;
  logic signed [33:0] m1_d, sqt_d;
  assign d1    = {1'b0, raw_temperature_i[19:3]} - {1'b0, t1, 1'b0};
  assign d2    = {1'b0, raw_temperature_i[19:4]} - {1'b0, t1};
  assign m1_d  = $signed(d1) * $signed(t2);
  assign sqt_d = $signed(d2) * $signed(d2);

  logic [33:0] s1_m1_q, s1_sqt_q;
  logic [19:0] s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q, s5_adcp_q, s6_adcp_q;
  logic [19:0] s7_adcp_q, s8_adcp_q;
  logic [31:0] s2_v1_q, s2_m3_q, s3_fine_q;
  logic [31:0] s4_tc_q, s5_tc_q, s6_tc_q, s7_tc_q, s8_tc_q, s9_tc_q, s10_tc_q, s11_tc_q;
  logic [32:0] s4_v1p_q;
  logic [63:0] s5_sq_q;
  logic [48:0] s5_a5_q, s5_a2_q, s6_a5_q, s6_a2_q, s7_a5_q, s7_a2_q;
  pp_t         s6_pp6_q, s6_pp3_q, s9_pp1_q, s10_ppn_q;
  logic [63:0] s7_s6_q, s7_s3_q, s8_v2_q, s8_v1b_q, s9_diff_q, s10_prod1_q;
  logic [63:0] s11_num_q;
  logic [30:0] s11_den_q;

  logic [31:0]        v1t_d, v2a_d, v2t_d, fine_d, tcw_d;
  logic signed [47:0] m3_d;
  logic signed [65:0] sq_d;
  logic signed [48:0] a5_d, a2_d;
  logic [20:0]        pb_d;
  logic [63:0]        prod1_d;

  assign v1t_d   = $signed(s1_m1_q[31:0]) >>> 11;
  assign v2a_d   = $signed(s1_sqt_q[31:0]) >>> 12;
  assign m3_d    = $signed(v2a_d) * $signed(t3);
  assign v2t_d   = $signed(s2_m3_q) >>> 14;
  assign fine_d  = s2_v1_q + v2t_d;
  assign tcw_d   = {s3_fine_q[29:0], 2'b00} + s3_fine_q + 32'd128;
  assign sq_d    = $signed(s4_v1p_q) * $signed(s4_v1p_q);
  assign a5_d    = $signed(s4_v1p_q) * $signed(p5);
  assign a2_d    = $signed(s4_v1p_q) * $signed(p2);
  assign pb_d    = P_BASE - {1'b0, s8_adcp_q};
  assign prod1_d = pp_sum(s9_pp1_q);

  // Temperature and pressure offset stages up to the divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_m1_q     <= m1_d;
      s1_sqt_q    <= sqt_d;
      s1_adcp_q   <= raw_pressure_i;
      s2_v1_q     <= v1t_d;
      s2_m3_q     <= m3_d[31:0];
      s2_adcp_q   <= s1_adcp_q;
      s3_fine_q   <= fine_d;
      s3_adcp_q   <= s2_adcp_q;
      s4_tc_q     <= $signed(tcw_d) >>> 8;
      s4_v1p_q    <= {s3_fine_q[31], s3_fine_q} - FINE_OFFSET;
      s4_adcp_q   <= s3_adcp_q;
      s5_sq_q     <= sq_d[63:0];
      s5_a5_q     <= a5_d;
      s5_a2_q     <= a2_d;
      s5_tc_q     <= s4_tc_q;
      s5_adcp_q   <= s4_adcp_q;
      s6_pp6_q    <= mul_pp(s5_sq_q, sx16(p6));
      s6_pp3_q    <= mul_pp(s5_sq_q, sx16(p3));
      s6_a5_q     <= s5_a5_q;
      s6_a2_q     <= s5_a2_q;
      s6_tc_q     <= s5_tc_q;
      s6_adcp_q   <= s5_adcp_q;
      s7_s6_q     <= pp_sum(s6_pp6_q);
      s7_s3_q     <= pp_sum(s6_pp3_q);
      s7_a5_q     <= s6_a5_q;
      s7_a2_q     <= s6_a2_q;
      s7_tc_q     <= s6_tc_q;
      s7_adcp_q   <= s6_adcp_q;
      s8_v2_q     <= s7_s6_q + {s7_a5_q[46:0], 17'b0}
                     + {{13{p4[15]}}, p4, 35'b0};
      s8_v1b_q    <= {{8{s7_s3_q[63]}}, s7_s3_q[63:8]}
                     + {{3{s7_a2_q[48]}}, s7_a2_q, 12'b0} + V1_BIAS;
      s8_tc_q     <= s7_tc_q;
      s8_adcp_q   <= s7_adcp_q;
      s9_pp1_q    <= mul_pp(s8_v1b_q, {48'b0, p1});
      s9_diff_q   <= {12'b0, pb_d, 31'b0} - s8_v2_q;
      s9_tc_q     <= s8_tc_q;
      s10_prod1_q <= prod1_d;
      s10_ppn_q   <= mul_pp(s9_diff_q, DIV_SCALE);
      s10_tc_q    <= s9_tc_q;
      s11_den_q   <= s10_prod1_q[63:33];
      s11_num_q   <= pp_sum(s10_ppn_q);
      s11_tc_q    <= s10_tc_q;
    end
  end

  // Pressure quotient.
  logic [63:0] quot;
  logic        div_zero;
  logic [31:0] div_tc;

  bsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (fv_q[10]),
    .num_i       (s11_num_q),
    .den_i       (s11_den_q),
    .tc_i        (s11_tc_q),
    .out_valid_o (div_valid),
    .quot_o      (quot),
    .zero_o      (div_zero),
    .tc_o        (div_tc)
  );

  // Second-order pressure correction.
  logic [63:0] q13_d;
  assign q13_d = $signed(quot) >>> 13;

  pp_t         b1_ppa_q, b1_pp8_q, b3_ppq_q;
  logic [63:0] b1_p_q, b1_q13_q, b2_p_q, b2_q13_q, b2_aq_q, b2_bp_q;
  logic [63:0] b3_p_q, b3_bsh_q, b4_p_q, b4_bsh_q, b4_av_q, b5_s_q;
  logic [31:0] b1_tc_q, b2_tc_q, b3_tc_q, b4_tc_q, b5_tc_q;
  logic        b1_ok_q, b2_ok_q, b3_ok_q, b4_ok_q, b5_ok_q;
  logic [63:0] res_d;
  logic [31:0] temp_q, press_q;
  logic        pvalid_q;

  assign res_d = {{8{b5_s_q[63]}}, b5_s_q[63:8]} + {{44{p7[15]}}, p7, 4'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_ppa_q  <= mul_pp(sx16(p9), q13_d);
      b1_pp8_q  <= mul_pp(sx16(p8), quot);
      b1_p_q    <= quot;
      b1_q13_q  <= q13_d;
      b1_tc_q   <= div_tc;
      b1_ok_q   <= !div_zero;
      b2_aq_q   <= pp_sum(b1_ppa_q);
      b2_bp_q   <= pp_sum(b1_pp8_q);
      b2_p_q    <= b1_p_q;
      b2_q13_q  <= b1_q13_q;
      b2_tc_q   <= b1_tc_q;
      b2_ok_q   <= b1_ok_q;
      b3_ppq_q  <= mul_pp(b2_aq_q, b2_q13_q);
      b3_bsh_q  <= $signed(b2_bp_q) >>> 19;
      b3_p_q    <= b2_p_q;
      b3_tc_q   <= b2_tc_q;
      b3_ok_q   <= b2_ok_q;
      b4_av_q   <= $signed(pp_sum(b3_ppq_q)) >>> 25;
      b4_bsh_q  <= b3_bsh_q;
      b4_p_q    <= b3_p_q;
      b4_tc_q   <= b3_tc_q;
      b4_ok_q   <= b3_ok_q;
      b5_s_q    <= b4_p_q + b4_av_q + b4_bsh_q;
      b5_tc_q   <= b4_tc_q;
      b5_ok_q   <= b4_ok_q;
      temp_q    <= b5_tc_q;
      press_q   <= b5_ok_q ? res_d[31:0] : 32'd0;
      pvalid_q  <= b5_ok_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign pressure_q24_8_o    = press_q;
  assign pressure_valid_o    = pvalid_q;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the pipelined barometric temperature and pressure compensation.
`timescale 1ns / 1ps
module testbench;
  import bsc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_CAL_TEMP;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic        pressure_valid_o;

  barometric_sensor_compensation dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_valid;
  } reading_t;

  // Scoreboard: holds the calibration copy and the queue of predicted readings.
  class compensation_board;
    logic [47:0] cal_temp;
    logic [63:0] cal_press_1;
    logic [63:0] cal_press_2;
    logic [15:0] cal_press_3;
    reading_t    predicted[$];
    int unsigned errors;

    function new();
      cal_temp = '0;
      cal_press_1 = '0;
      cal_press_2 = '0;
      cal_press_3 = '0;
      errors = 0;
    endfunction

    function void set_cal(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        CFG_CAL_TEMP:    cal_temp = data[47:0];
        CFG_CAL_PRESS_1: cal_press_1 = data;
        CFG_CAL_PRESS_2: cal_press_2 = data;
        default:         cal_press_3 = data[15:0];
      endcase
    endfunction

    // Keep the low 32 bits and sign-extend them.
    function longint wrap32(longint x);
      int r;
      r = int'(x);
      return r;
    endfunction

    // Predict the reading for one accepted raw pair.
    function void note_reading(logic [19:0] raw_t, logic [19:0] raw_p);
      longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint d1, d2, v1, v2, fine, tc, p, num, q, a, b;
      reading_t r;
      adc_t = {44'd0, raw_t};
      adc_p = {44'd0, raw_p};
      t1 = {48'd0, cal_temp[15:0]};
      t2 = $signed(cal_temp[31:16]);
      t3 = $signed(cal_temp[47:32]);
      p1 = {48'd0, cal_press_1[15:0]};
      p2 = $signed(cal_press_1[31:16]);
      p3 = $signed(cal_press_1[47:32]);
      p4 = $signed(cal_press_1[63:48]);
      p5 = $signed(cal_press_2[15:0]);
      p6 = $signed(cal_press_2[31:16]);
      p7 = $signed(cal_press_2[47:32]);
      p8 = $signed(cal_press_2[63:48]);
      p9 = $signed(cal_press_3);
      // Temperature step, wrapping at 32 bits.
      d1 = (adc_t >>> 3) - (t1 <<< 1);
      v1 = wrap32(d1 * t2) >>> 11;
      d2 = (adc_t >>> 4) - t1;
      v2 = wrap32(d2 * d2) >>> 12;
      v2 = wrap32(v2 * t3) >>> 14;
      fine = wrap32(v1 + v2);
      tc = wrap32(fine * 5 + 128) >>> 8;
      // Pressure step, wrapping at 64 bits.
      v1 = fine - 128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.temp_centi = tc[31:0];
      r.press_q24_8 = '0;
      r.press_valid = 1'b0;
      if (v1 != 0) begin
        p = 1048576 - adc_p;
        num = ((p <<< 31) - v2) * 3125;
        // A divisor of minus one negates the dividend with wrap.
        if (v1 == -1) p = -num;
        else p = num / v1;
        q = p >>> 13;
        a = (p9 * q * q) >>> 25;
        b = (p8 * p) >>> 19;
        p = ((p + a + b) >>> 8) + (p7 <<< 4);
        r.press_q24_8 = p[31:0];
        r.press_valid = 1'b1;
      end
      predicted.push_back(r);
    endfunction

    // Compare one output beat with the oldest prediction.
    function void check_reading(reading_t act);
      reading_t want;
      if (predicted.size() == 0) begin
        $display("%0t: unexpected output beat %h", $time, act);
        errors++;
        return;
      end
      want = predicted.pop_front();
      if (act.temp_centi !== want.temp_centi) begin
        $display("%0t: temperature_centi expected %h actual %h", $time,
                 want.temp_centi, act.temp_centi);
        errors++;
      end
      if (act.press_q24_8 !== want.press_q24_8) begin
        $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                 want.press_q24_8, act.press_q24_8);
        errors++;
      end
      if (act.press_valid !== want.press_valid) begin
        $display("%0t: pressure_valid expected %b actual %b", $time,
                 want.press_valid, act.press_valid);
        errors++;
      end
    endfunction
  endclass

  compensation_board board = new();
  bit calm_phase = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned out_stall = 0;

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: check accepted beats and stall the ready line in bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_reading({temperature_centi_o, pressure_q24_8_o, pressure_valid_o});
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(0, 17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_cal(cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_cal(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_cal(logic [47:0] ct, logic [63:0] c1, logic [63:0] c2, logic [15:0] c3);
    write_cal(CFG_CAL_TEMP, {16'd0, ct});
    write_cal(CFG_CAL_PRESS_1, c1);
    write_cal(CFG_CAL_PRESS_2, c2);
    write_cal(CFG_CAL_PRESS_3, {48'd0, c3});
  endtask

  // Wait until the pipeline has emptied, then let it settle.
  task automatic drain();
    while (board.predicted.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Send one raw pair as a beat, then maybe idle for a burst.
  task automatic send_pair(logic [19:0] rt, logic [19:0] rp);
    in_valid_i <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i <= rp;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_reading(rt, rp);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic directed_pairs();
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'd0, 20'hFFFFF);
    send_pair(20'hFFFFF, 20'd0);
    send_pair(20'd519888, 20'd415148);
    send_pair(20'h55555, 20'hAAAAA);
    send_pair(20'hAAAAA, 20'h55555);
    send_pair(20'd1, 20'd1);
  endtask

  task automatic random_pairs(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        send_pair(20'($urandom_range(20'hFFFFF, 0)), 20'($urandom_range(20'hFFFFF, 0)));
      else
        send_pair(20'($urandom_range(560000, 450000)), 20'($urandom_range(500000, 250000)));
    end
    in_valid_i <= 1'b0;
  endtask

  // Typical coefficients of a production part.
  localparam logic [47:0] TypTemp = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypP1 = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TypP2 = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TypP3 = 16'd6000;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset calibration: divisor is zero, so pressure is forced off.
    directed_pairs();
    in_valid_i <= 1'b0;
    drain();
    load_cal('1, '1, '1, '1);
    directed_pairs();
    in_valid_i <= 1'b0;
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
             {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
    directed_pairs();
    in_valid_i <= 1'b0;
    drain();
    load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
             {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
    directed_pairs();
    in_valid_i <= 1'b0;
    drain();
    load_cal(TypTemp, TypP1, TypP2, TypP3);
    random_pairs(300);
    // Sender holds off until every reading is out.
    drain();
    for (int i = 0; i < 5; i++) begin
      load_cal(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
               {$urandom(), $urandom()}, 16'($urandom()));
      random_pairs(120);
      drain();
    end
    load_cal(TypTemp, TypP1, TypP2, TypP3);
    calm_phase = 1'b1;
    random_pairs(250);
    drain();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
